// ----- rtl/cdq_pkg.sv -----
// Shared types and codes for the circular double-ended queue.
package cdq_pkg;

  localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
  localparam logic [1:0] CMD_PUSH_BACK  = 2'd1;
  localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
  localparam logic [1:0] CMD_POP_BACK   = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic signed [31:0] EMPTY_WORD = -32'sd1;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] data_out;
    logic [1:0]         status;
    logic [3:0]         fill_count;
  } out_item_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic load_out;
  } ctrl_cmd_t;

endpackage

// ----- rtl/cdq_ctrl.sv -----
// Controller state machine that sequences one transaction at a time.
module cdq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output cdq_pkg::ctrl_cmd_t cmd
);
  import cdq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  assign cmd.load_in  = in_valid && (state_r == S_IDLE);
  assign cmd.exec     = (state_r == S_EXEC);
  assign cmd.load_out = (state_r == S_LOAD) && slot_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_EXEC))
    else $error("accepted transaction did not start execution");
  a_exec_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |=> (state_r == S_LOAD))
    else $error("execution did not proceed to result load");
  a_load_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD && out_valid_r && !out_ready) |=> (state_r == S_LOAD))
    else $error("result load left while the output register was occupied");
`endif

endmodule

// ----- rtl/cdq_dpath.sv -----
// Datapath with the entry store, head and tail pointers, count and result register.
module cdq_dpath #(
  parameter int DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cdq_pkg::ctrl_cmd_t cmd,
  input  cdq_pkg::in_item_t  in_data,
  output cdq_pkg::out_item_t out_data
);
  import cdq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic signed [31:0] mem [DEPTH];

  in_item_t           item_r;
  logic [AW-1:0]      head_r, head_nxt;
  logic [AW-1:0]      tail_r, tail_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic signed [31:0] rd_data_r;
  logic [1:0]         st_r, st_nxt;
  logic               pop_ok_r, pop_ok_nxt;
  out_item_t          out_r;

  logic [AW-1:0]      head_up, head_dn, tail_up, tail_dn;
  logic               we;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [CW+3:0]      cnt_ext;

  assign head_up = (head_r == LAST_IDX) ? '0 : head_r + AW'(1);
  assign head_dn = (head_r == '0) ? LAST_IDX : head_r - AW'(1);
  assign tail_up = (tail_r == LAST_IDX) ? '0 : tail_r + AW'(1);
  assign tail_dn = (tail_r == '0) ? LAST_IDX : tail_r - AW'(1);

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cnt_nxt    = cnt_r;
    st_nxt     = ST_DONE;
    pop_ok_nxt = 1'b0;
    we         = 1'b0;
    wr_addr    = tail_r;
    rd_addr    = head_r;
    case (item_r.command)
      CMD_PUSH_FRONT: begin
        if (cnt_r == FULL_CNT) begin
          st_nxt = ST_FULL;
        end else begin
          head_nxt = head_dn;
          wr_addr  = head_dn;
          we       = cmd.exec;
          cnt_nxt  = cnt_r + CW'(1);
        end
      end
      CMD_PUSH_BACK: begin
        if (cnt_r == FULL_CNT) begin
          st_nxt = ST_FULL;
        end else begin
          tail_nxt = tail_up;
          wr_addr  = tail_r;
          we       = cmd.exec;
          cnt_nxt  = cnt_r + CW'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (cnt_r == '0) begin
          st_nxt = ST_EMPTY;
        end else begin
          pop_ok_nxt = 1'b1;
          rd_addr    = head_r;
          head_nxt   = head_up;
          cnt_nxt    = cnt_r - CW'(1);
        end
      end
      CMD_POP_BACK: begin
        if (cnt_r == '0) begin
          st_nxt = ST_EMPTY;
        end else begin
          pop_ok_nxt = 1'b1;
          rd_addr    = tail_dn;
          tail_nxt   = tail_dn;
          cnt_nxt    = cnt_r - CW'(1);
        end
      end
      default: begin
        st_nxt = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= item_r.data_in;
    end
    if (cmd.exec) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.exec) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign cnt_ext = {4'b0000, cnt_r};

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      item_r <= in_data;
    end
    if (cmd.exec) begin
      st_r     <= st_nxt;
      pop_ok_r <= pop_ok_nxt;
    end
    if (cmd.load_out) begin
      out_r.status     <= st_r;
      out_r.fill_count <= cnt_ext[3:0];
      if (pop_ok_r) begin
        out_r.data_out <= rd_data_r;
      end else if (st_r == ST_EMPTY) begin
        out_r.data_out <= EMPTY_WORD;
      end else begin
        out_r.data_out <= '0;
      end
    end
  end

  assign out_data = out_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("entry count exceeds the store depth");
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (head_r == tail_r))
    else $error("pointers differ while the queue is empty");
  a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == FULL_CNT) |-> (head_r == tail_r))
    else $error("pointers differ while the queue is full");
`endif

endmodule

// ----- rtl/circular_deque.sv -----
// Top level of the circular double-ended queue.
// Each transaction carries one command (push front, push back, pop front, pop back) and
// returns exactly one result with the popped word, a status and the entry count after the
// command. After a transaction is accepted, its command is captured in the command register,
// then the pointers are updated and the entry store is accessed into the read-data register,
// and the result is loaded into the output register once that register is free or being taken.
// The next transaction is accepted as soon as the previous one has reached the output register,
// even if that result has not been taken yet. A push on a full queue is refused without writing,
// and a pop on an empty queue returns -1; neither changes the queue.
module circular_deque #(
  parameter int DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cdq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cdq_pkg::out_item_t out_data
);
  import cdq_pkg::*;

  ctrl_cmd_t cmd;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  cdq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

// ----- verif/circular_deque_tb.sv -----
// Self-checking testbench for the circular double-ended queue with a scoreboard class.
`timescale 1ns / 100ps

module circular_deque_tb;
  import cdq_pkg::*;

  localparam int DEPTH = 8;
  localparam int CYCLE_LIMIT = 100000;
  localparam int RANDOM_COMMANDS = 1100;

  typedef enum int {BIAS_FILL, BIAS_DRAIN, BIAS_EVEN} bias_t;

  class deque_scoreboard;
    logic signed [31:0] slots [DEPTH];
    int head = 0;
    int tail = 0;
    int held = 0;
    int peak = 0;
    out_item_t predicted_replies [$];
    int errors = 0;
    int accepted = 0;
    int checked = 0;
    int full_refusals = 0;
    int empty_refusals = 0;

    function void note_command(in_item_t item);
      out_item_t reply;
      reply.data_out = '0;
      reply.status = ST_DONE;
      case (item.command)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (held >= DEPTH) begin
            reply.status = ST_FULL;
            full_refusals++;
          end else if (item.command == CMD_PUSH_FRONT) begin
            head = (head + DEPTH - 1) % DEPTH;
            slots[head] = item.data_in;
            held++;
          end else begin
            slots[tail] = item.data_in;
            tail = (tail + 1) % DEPTH;
            held++;
          end
        end
        default: begin
          if (held == 0) begin
            reply.status = ST_EMPTY;
            reply.data_out = EMPTY_WORD;
            empty_refusals++;
          end else if (item.command == CMD_POP_FRONT) begin
            reply.data_out = slots[head];
            head = (head + 1) % DEPTH;
            held--;
          end else begin
            tail = (tail + DEPTH - 1) % DEPTH;
            reply.data_out = slots[tail];
            held--;
          end
        end
      endcase
      if (held > peak) peak = held;
      reply.fill_count = 4'(held);
      predicted_replies.insert(predicted_replies.size(), reply);
      accepted++;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (predicted_replies.size() == 0) begin
        $display("%0t: unexpected result data_out=%0d status=%0d fill_count=%0d",
                 $time, $signed(got.data_out), got.status, got.fill_count);
        errors++;
        return;
      end
      want = predicted_replies[0];
      predicted_replies.delete(0);
      checked++;
      if (got.data_out !== want.data_out) begin
        $display("%0t: data_out mismatch, expected %0d, actual %0d",
                 $time, $signed(want.data_out), $signed(got.data_out));
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, want.status, got.status);
        errors++;
      end
      if (got.fill_count !== want.fill_count) begin
        $display("%0t: fill_count mismatch, expected %0d, actual %0d",
                 $time, want.fill_count, got.fill_count);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  bit steady = 1'b0;
  int cycles = 0;
  deque_scoreboard sb = new();

  circular_deque #(.DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycles, sb.predicted_replies.size());
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_command(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 13);
  end

  task automatic send_command(input logic [1:0] cmd, input logic signed [31:0] word);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{command: cmd, data_in: word};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic run_directed();
    send_command(CMD_POP_FRONT, 32'sd5);
    send_command(CMD_POP_BACK, 32'sd6);
    send_command(CMD_PUSH_BACK, 32'sh7fffffff);
    send_command(CMD_PUSH_FRONT, 32'sh80000000);
    send_command(CMD_PUSH_BACK, -32'sd1);
    send_command(CMD_PUSH_FRONT, 32'sd0);
    send_command(CMD_PUSH_BACK, 32'sh55555555);
    send_command(CMD_PUSH_FRONT, 32'shaaaaaaaa);
    send_command(CMD_PUSH_BACK, 32'sd1);
    send_command(CMD_PUSH_FRONT, 32'sh12345678);
    send_command(CMD_PUSH_FRONT, 32'sd99);
    send_command(CMD_PUSH_BACK, 32'sd98);
    for (int n = 0; n < 4; n++) begin
      send_command(CMD_POP_BACK, 32'sd0);
      send_command(CMD_POP_FRONT, -32'sd1);
    end
    send_command(CMD_POP_FRONT, 32'sd0);
    send_command(CMD_PUSH_BACK, 32'sd7);
    send_command(CMD_POP_BACK, 32'sd0);
    send_command(CMD_PUSH_FRONT, -32'sd8);
    send_command(CMD_POP_FRONT, 32'sd0);
  endtask

  task automatic run_random(input int count);
    bias_t mode;
    int pick;
    bit push;
    logic [1:0] cmd;
    logic signed [31:0] word;
    mode = BIAS_EVEN;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) mode = bias_t'($urandom_range(0, 2));
      steady = (n >= 450 && n < 700);
      pick = $urandom_range(0, 99);
      case (mode)
        BIAS_FILL:  push = (pick < 80);
        BIAS_DRAIN: push = (pick < 20);
        default:    push = (pick < 50);
      endcase
      if (push) cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      else cmd = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
      case ($urandom_range(0, 9))
        0:       word = 32'sh7fffffff;
        1:       word = 32'sh80000000;
        2:       word = -32'sd1;
        3:       word = 32'sd0;
        default: word = $urandom;
      endcase
      send_command(cmd, word);
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random(RANDOM_COMMANDS);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.predicted_replies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Checked %0d of %0d commands; peak fill %0d of %0d.",
             sb.checked, sb.accepted, sb.peak, DEPTH);
    $display("Refused pushes on a full queue: %0d; pops on an empty queue: %0d.",
             sb.full_refusals, sb.empty_refusals);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/cdq_pkg.sv
rtl/cdq_ctrl.sv
rtl/cdq_dpath.sv
rtl/circular_deque.sv
verif/circular_deque_tb.sv
